// ----- rtl/core/rlivt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlivt_pkg
// Shared codes and beat layout for the run-length item value table.
// ----------------------------------------------------------------------------
package rlivt_pkg;

  localparam int KIND_W     = 3;
  localparam int POS_W      = 10;
  localparam int CNT_W      = 11;
  localparam int WORD_W     = 32;
  localparam int LSIZE_W    = 11;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INVAL     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_INV_RANGE = 3'd6;
  localparam logic [KIND_W-1:0] KIND_MOVE      = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WRITE,
    OP_INVAL,
    OP_SHIFT_UP,
    OP_SHIFT_DOWN,
    OP_LOAD,
    OP_READ_SHIFT
  } cell_op_t;

endpackage

// ----- rtl/core/rlivt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlivt_cell
// One slot of the table: a valid bit, a length word and a readout stage.
// ----------------------------------------------------------------------------
module rlivt_cell #(
  parameter int IDX          = 0,
  parameter int SIZE_W       = 11,
  parameter int LENGTH_WIDTH = 32
) (
  input  logic                    clk,
  input  rlivt_pkg::cell_op_t     op,
  input  logic [SIZE_W-1:0]       lo,
  input  logic [SIZE_W-1:0]       hi,
  input  logic [LENGTH_WIDTH-1:0] wr_word,
  input  logic                    left_valid,
  input  logic [LENGTH_WIDTH-1:0] left_word,
  input  logic                    right_valid,
  input  logic [LENGTH_WIDTH-1:0] right_word,
  input  logic                    rd_in_valid,
  input  logic [LENGTH_WIDTH-1:0] rd_in_word,
  output logic                    valid,
  output logic [LENGTH_WIDTH-1:0] word,
  output logic                    rd_valid,
  output logic [LENGTH_WIDTH-1:0] rd_word
);
  import rlivt_pkg::*;

  localparam logic [SIZE_W-1:0] ME = SIZE_W'(IDX);

  logic in_range;

  assign in_range = (ME >= lo) && (ME < hi);

  always_ff @(posedge clk) begin
    unique case (op)
      OP_NOP: begin
      end
      OP_WRITE: begin
        if (ME == hi) begin
          valid <= 1'b1;
          word  <= wr_word;
        end else if (in_range) begin
          valid <= 1'b0;
        end
      end
      OP_INVAL: begin
        if (in_range) begin
          valid <= 1'b0;
        end
      end
      OP_SHIFT_UP: begin
        if (ME > lo) begin
          valid <= left_valid;
          word  <= left_word;
        end else if (ME == lo) begin
          valid <= 1'b0;
        end
      end
      OP_SHIFT_DOWN: begin
        if (ME >= lo) begin
          valid <= right_valid;
          word  <= right_word;
        end
      end
      OP_LOAD: begin
        rd_valid <= valid;
        rd_word  <= word;
      end
      OP_READ_SHIFT: begin
        rd_valid <= rd_in_valid;
        rd_word  <= rd_in_word;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/rlivt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlivt_ctrl
// Sequencer: decodes a request beat, drives the cell row for as many steps
// as the operation needs, tracks the list size and returns the result beat.
// ----------------------------------------------------------------------------
module rlivt_ctrl #(
  parameter int MAX_ITEMS    = 1024,
  parameter int LENGTH_WIDTH = 32,
  parameter int SIZE_W       = 11
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rlivt_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [rlivt_pkg::KIND_W-1:0]     s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rlivt_pkg::OUT_DATA_W-1:0] m_tdata,
  output rlivt_pkg::cell_op_t              op,
  output logic [SIZE_W-1:0]                lo,
  output logic [SIZE_W-1:0]                hi,
  output logic [LENGTH_WIDTH-1:0]          wr_word,
  input  logic                             rd_valid,
  input  logic [LENGTH_WIDTH-1:0]          rd_word
);
  import rlivt_pkg::*;

  localparam int SUM_W = ((SIZE_W > POS_W) ? SIZE_W : POS_W) + 2;
  localparam logic [SUM_W-1:0] MAX_X = SUM_W'(MAX_ITEMS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  state_t                  state;
  logic [SIZE_W-1:0]       size;
  logic [CNT_W-1:0]        steps;
  logic [POS_W-1:0]        rd_pos;
  logic                    res_found;
  logic                    res_ovf;

  logic [POS_W-1:0]        in_pos;
  logic [POS_W-1:0]        in_pos2;
  logic [CNT_W-1:0]        in_cnt;
  logic [WORD_W-1:0]       in_word;
  logic [LENGTH_WIDTH+WORD_W-1:0] in_word_ext;
  logic [LENGTH_WIDTH+WORD_W-1:0] rd_word_ext;

  logic [SUM_W-1:0]        pos_x;
  logic [SUM_W-1:0]        pos2_x;
  logic [SUM_W-1:0]        cnt_x;
  logic [SUM_W-1:0]        size_x;
  logic [SUM_W-1:0]        base_x;
  logic [SUM_W-1:0]        end_x;
  logic [SUM_W-1:0]        avail_x;

  cell_op_t                dec_op;
  logic [SUM_W-1:0]        dec_lo;
  logic [SUM_W-1:0]        dec_hi;
  logic [SUM_W-1:0]        dec_steps;
  logic [SUM_W-1:0]        dec_size;
  logic                    dec_found;
  logic                    dec_ovf;

  logic                    out_valid_bit;
  logic [WORD_W-1:0]       out_word;
  logic [LSIZE_W-1:0]      out_size;
  logic [SUM_W+LSIZE_W-1:0] size_ext;

  assign in_pos  = s_tdata[9:0];
  assign in_pos2 = s_tdata[19:10];
  assign in_cnt  = s_tdata[30:20];
  assign in_word = s_tdata[62:31];

  assign in_word_ext = {{LENGTH_WIDTH{1'b0}}, in_word};
  assign rd_word_ext = {{WORD_W{1'b0}}, rd_word};

  assign pos_x  = SUM_W'(in_pos);
  assign pos2_x = SUM_W'(in_pos2);
  assign cnt_x  = SUM_W'(in_cnt);
  assign size_x = SUM_W'(size);
  assign base_x = (pos_x > size_x) ? pos_x : size_x;
  assign avail_x = size_x - pos_x;

  always_comb begin
    dec_op    = OP_NOP;
    dec_lo    = '0;
    dec_hi    = '0;
    dec_steps = SUM_W'(1);
    dec_size  = size_x;
    dec_found = 1'b0;
    dec_ovf   = 1'b0;
    end_x     = pos_x + cnt_x;
    unique case (s_tuser)
      KIND_CLEAR: begin
        dec_size = '0;
      end
      KIND_SET: begin
        if (pos_x >= MAX_X) begin
          dec_ovf = 1'b1;
        end else begin
          dec_op = OP_WRITE;
          dec_hi = pos_x;
          if (pos_x >= size_x) begin
            dec_lo   = size_x;
            dec_size = pos_x + SUM_W'(1);
          end else begin
            dec_lo = pos_x;
          end
        end
      end
      KIND_INVAL: begin
        if (pos_x < size_x) begin
          dec_op = OP_INVAL;
          dec_lo = pos_x;
          dec_hi = pos_x + SUM_W'(1);
        end
      end
      KIND_READ: begin
        if (pos_x < size_x) begin
          dec_op    = OP_LOAD;
          dec_found = 1'b1;
        end
      end
      KIND_INSERT: begin
        end_x = base_x + cnt_x;
        if (cnt_x != '0) begin
          if (end_x > MAX_X) begin
            dec_ovf = 1'b1;
          end else begin
            if (pos_x < size_x) begin
              dec_op    = OP_SHIFT_UP;
              dec_lo    = pos_x;
              dec_steps = cnt_x;
            end else begin
              dec_op = OP_INVAL;
              dec_lo = size_x;
              dec_hi = end_x;
            end
            dec_size = end_x;
          end
        end
      end
      KIND_REMOVE: begin
        if (pos_x < size_x && cnt_x != '0) begin
          dec_op    = OP_SHIFT_DOWN;
          dec_lo    = pos_x;
          dec_steps = (cnt_x < avail_x) ? cnt_x : avail_x;
          dec_size  = size_x - ((cnt_x < avail_x) ? cnt_x : avail_x);
        end
      end
      KIND_INV_RANGE: begin
        if (cnt_x != '0) begin
          if (end_x > MAX_X) begin
            dec_ovf = 1'b1;
          end else begin
            dec_op = OP_INVAL;
            dec_hi = end_x;
            if (end_x > size_x) begin
              dec_lo   = (pos_x < size_x) ? pos_x : size_x;
              dec_size = end_x;
            end else begin
              dec_lo = pos_x;
            end
          end
        end
      end
      KIND_MOVE: begin
        if (pos_x < size_x && pos2_x < size_x && pos_x != pos2_x) begin
          dec_op = OP_INVAL;
          dec_lo = (pos_x < pos2_x) ? pos_x : pos2_x;
          dec_hi = ((pos_x < pos2_x) ? pos2_x : pos_x) + SUM_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  assign out_valid_bit = res_found & rd_valid;
  assign out_word      = out_valid_bit ? rd_word_ext[WORD_W-1:0] : '0;
  assign size_ext      = {{LSIZE_W{1'b0}}, size_x};
  assign out_size      = size_ext[LSIZE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_NOP;
      size      <= '0;
      m_tvalid  <= 1'b0;
      steps     <= '0;
      res_found <= 1'b0;
      res_ovf   <= 1'b0;
    end else begin
      if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op        <= dec_op;
            lo        <= dec_lo[SIZE_W-1:0];
            hi        <= dec_hi[SIZE_W-1:0];
            steps     <= dec_steps[CNT_W-1:0];
            size      <= dec_size[SIZE_W-1:0];
            res_found <= dec_found;
            res_ovf   <= dec_ovf;
            rd_pos    <= in_pos;
            wr_word   <= in_word_ext[LENGTH_WIDTH-1:0];
            state     <= (dec_op == OP_NOP) ? ST_FINISH : ST_RUN;
          end
        end
        ST_RUN: begin
          if (steps == CNT_W'(1)) begin
            if (op == OP_LOAD && rd_pos != '0) begin
              op    <= OP_READ_SHIFT;
              steps <= CNT_W'(rd_pos);
            end else begin
              op    <= OP_NOP;
              state <= ST_FINISH;
            end
          end else begin
            steps <= steps - CNT_W'(1);
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {2'b00, res_ovf, out_size, out_word, out_valid_bit, res_found};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/run_length_item_value_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_item_value_table_core
// Slot list with clear, set, invalidate, read, insert, remove, range
// invalidate and move over a row of shifting cells, one cell per slot.
// ----------------------------------------------------------------------------
// Once a request is taken, the sequencer drives the cell row in ST_RUN and
// registers the result beat in ST_FINISH; clear and a no-op skip the row.
// An insert inside the list shifts the row up by the count, remove shifts
// it down by the clipped count, read loads the readout stages and shifts
// them by the position, the other kinds write or clear a range of slots.
// One request at a time, taken in ST_IDLE; the row shifts one slot per cycle.
// Reset clears the list size and the handshake; slot contents are not reset.
// ----------------------------------------------------------------------------
module run_length_item_value_table_core #(
  parameter int MAX_ITEMS    = 1024,
  parameter int LENGTH_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // position[9:0], second_position[19:10], count[30:20], length_bits[62:31]
  input  logic [rlivt_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind[2:0]
  input  logic [rlivt_pkg::KIND_W-1:0]     s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // found[0], length_valid[1], length_word[33:2], list_size[44:34],
  // overflow_error[45]
  output logic [rlivt_pkg::OUT_DATA_W-1:0] m_tdata
);
  import rlivt_pkg::*;

  localparam int SIZE_W = $clog2(MAX_ITEMS + 1);

  cell_op_t                op;
  logic [SIZE_W-1:0]       lo;
  logic [SIZE_W-1:0]       hi;
  logic [LENGTH_WIDTH-1:0] wr_word;

  logic                    chain_valid [MAX_ITEMS+2];
  logic [LENGTH_WIDTH-1:0] chain_word  [MAX_ITEMS+2];
  logic                    rd_valid    [MAX_ITEMS+1];
  logic [LENGTH_WIDTH-1:0] rd_word     [MAX_ITEMS+1];

  assign chain_valid[0]           = 1'b0;
  assign chain_word[0]            = '0;
  assign chain_valid[MAX_ITEMS+1] = 1'b0;
  assign chain_word[MAX_ITEMS+1]  = '0;
  assign rd_valid[MAX_ITEMS]      = 1'b0;
  assign rd_word[MAX_ITEMS]       = '0;

  rlivt_ctrl #(
    .MAX_ITEMS    (MAX_ITEMS),
    .LENGTH_WIDTH (LENGTH_WIDTH),
    .SIZE_W       (SIZE_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .op       (op),
    .lo       (lo),
    .hi       (hi),
    .wr_word  (wr_word),
    .rd_valid (rd_valid[0]),
    .rd_word  (rd_word[0])
  );

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    rlivt_cell #(
      .IDX          (i),
      .SIZE_W       (SIZE_W),
      .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_cell (
      .clk         (clk),
      .op          (op),
      .lo          (lo),
      .hi          (hi),
      .wr_word     (wr_word),
      .left_valid  (chain_valid[i]),
      .left_word   (chain_word[i]),
      .right_valid (chain_valid[i+2]),
      .right_word  (chain_word[i+2]),
      .rd_in_valid (rd_valid[i+1]),
      .rd_in_word  (rd_word[i+1]),
      .valid       (chain_valid[i+1]),
      .word        (chain_word[i+1]),
      .rd_valid    (rd_valid[i]),
      .rd_word     (rd_word[i])
    );
  end

endmodule
